FILE: design/gcr_pkg.sv
package gcr_pkg;

    localparam int NUM_PINS      = 54;
    localparam int BANK_BITS     = 32;
    localparam int HIGH_BITS     = 22;
    localparam int FSEL_WORDS    = 6;
    localparam int PINS_PER_FSEL = 10;
    localparam int FSEL_BITS     = 3;
    localparam int WIDE_BITS     = 2 * BANK_BITS;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        PULL_OFF  = 2'd0,
        PULL_DOWN = 2'd1,
        PULL_UP   = 2'd2
    } t_pull;

    localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

    localparam logic [4:0] REG_FSEL0 = 5'd0;
    localparam logic [4:0] REG_FSEL1 = 5'd1;
    localparam logic [4:0] REG_FSEL2 = 5'd2;
    localparam logic [4:0] REG_FSEL3 = 5'd3;
    localparam logic [4:0] REG_FSEL4 = 5'd4;
    localparam logic [4:0] REG_FSEL5 = 5'd5;
    localparam logic [4:0] REG_SET0  = 5'd6;
    localparam logic [4:0] REG_SET1  = 5'd7;
    localparam logic [4:0] REG_CLR0  = 5'd8;
    localparam logic [4:0] REG_CLR1  = 5'd9;
    localparam logic [4:0] REG_LEV0  = 5'd10;
    localparam logic [4:0] REG_LEV1  = 5'd11;
    localparam logic [4:0] REG_EVS0  = 5'd12;
    localparam logic [4:0] REG_EVS1  = 5'd13;
    localparam logic [4:0] REG_REN0  = 5'd14;
    localparam logic [4:0] REG_REN1  = 5'd15;
    localparam logic [4:0] REG_FEN0  = 5'd16;
    localparam logic [4:0] REG_FEN1  = 5'd17;
    localparam logic [4:0] REG_PULL  = 5'd18;
    localparam logic [4:0] REG_PCLK0 = 5'd19;
    localparam logic [4:0] REG_PCLK1 = 5'd20;

    typedef logic [NUM_PINS-1:0] t_pins;

    typedef struct packed {
        logic [1:0]           func;
        logic [4:0]           reg_index;
        logic [31:0]          write_data;
        logic [31:0]          pins_in_low;
        logic [HIGH_BITS-1:0] pins_in_high;
    } t_in_item;

    typedef struct packed {
        logic [31:0]          read_data;
        logic [31:0]          drive_low;
        logic [HIGH_BITS-1:0] drive_high;
        logic [31:0]          drive_enable_low;
        logic [HIGH_BITS-1:0] drive_enable_high;
        logic [31:0]          pull_up_low;
        logic [HIGH_BITS-1:0] pull_up_high;
        logic [31:0]          pull_down_low;
        logic [HIGH_BITS-1:0] pull_down_high;
        logic                 event_pending;
    } t_out_item;

    // handshake state shared by the two pipeline stages
    typedef struct packed {
        logic step;
        logic advance;
    } t_flow;

    // place a bank word at its pins, bits beyond the last pin dropped
    function automatic t_pins bank_bits(input logic [31:0] data, input logic bank);
        logic [WIDE_BITS-1:0] w;
        w = bank ? {data, 32'd0} : {32'd0, data};
        return w[NUM_PINS-1:0];
    endfunction

    function automatic logic [31:0] bank_read(input t_pins v, input logic bank);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        return bank ? w[WIDE_BITS-1:BANK_BITS] : w[BANK_BITS-1:0];
    endfunction

    function automatic t_pins bank_replace(input t_pins v, input logic [31:0] data,
                                           input logic bank);
        t_pins mask;
        mask = bank_bits('1, bank);
        return (v & ~mask) | bank_bits(data, bank);
    endfunction

endpackage

FILE: design/gpio_controller_registers.sv
// channel  valid        stall        payload
// input    i_in_valid   o_in_stall   i_in  (t_in_item)
// output   o_out_valid  i_out_stall  o_out (t_out_item)
//
// one item per clock while the output is not stalled; each item passes the input
// register, then the register-map logic into the result register
// synchronous active-low reset clears all pin state and empties both stages
// a stalled result holds the result register; the input stage keeps taking
// items until it holds one that cannot move on
module gpio_controller_registers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  gcr_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gcr_pkg::t_out_item o_out
);
    import gcr_pkg::*;

    t_flow     flow;
    t_in_item  item;
    t_out_item result;
    logic      advance;

    gcr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_advance  (advance),
        .o_flow     (flow),
        .o_item     (item)
    );

    gcr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flow   (flow),
        .i_item   (item),
        .o_result (result)
    );

    gcr_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flow      (flow),
        .i_result    (result),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

FILE: design/gcr_in_stage.sv
module gcr_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gcr_pkg::t_in_item i_in,
    input  logic              i_advance,
    output gcr_pkg::t_flow    o_flow,
    output gcr_pkg::t_in_item o_item
);
    import gcr_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     accept;

    // the held item leaves whenever the result register can take it
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
    end

    assign o_flow.step    = r_valid && i_advance;
    assign o_flow.advance = i_advance;
    assign o_item         = r_item;

endmodule

FILE: design/gcr_core.sv
module gcr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcr_pkg::t_flow     i_flow,
    input  gcr_pkg::t_in_item  i_item,
    output gcr_pkg::t_out_item o_result
);
    import gcr_pkg::*;

    logic [FSEL_BITS-1:0] r_fsel [NUM_PINS];
    logic [FSEL_BITS-1:0] n_fsel [NUM_PINS];
    logic [1:0]           r_pull [NUM_PINS];
    logic [1:0]           n_pull [NUM_PINS];
    t_pins                r_latch, n_latch;
    t_pins                r_event, n_event;
    t_pins                r_rise, n_rise;
    t_pins                r_fall, n_fall;
    t_pins                r_last, n_last;
    logic [1:0]           r_pull_ctl, n_pull_ctl;

    logic [31:0]          fsel_word;
    logic [31:0]          rd;
    t_pins                sel;
    t_pins                levels;
    t_pins                en, up, down;
    logic [WIDE_BITS-1:0] w_latch, w_en, w_up, w_down;

    // function select word addressed by the index, pins past the last read 0
    always_comb begin
        fsel_word = '0;
        for (int w = 0; w < FSEL_WORDS; w++) begin
            for (int k = 0; k < PINS_PER_FSEL; k++) begin
                if (w * PINS_PER_FSEL + k < NUM_PINS && i_item.reg_index == 5'(w)) begin
                    fsel_word[FSEL_BITS*k +: FSEL_BITS] = r_fsel[w * PINS_PER_FSEL + k];
                end
            end
        end
    end

    assign levels = t_pins'(WIDE_BITS'({i_item.pins_in_high, i_item.pins_in_low}));

    always_comb begin
        n_fsel     = r_fsel;
        n_pull     = r_pull;
        n_latch    = r_latch;
        n_event    = r_event;
        n_rise     = r_rise;
        n_fall     = r_fall;
        n_last     = r_last;
        n_pull_ctl = r_pull_ctl;
        rd         = '0;
        sel        = bank_bits(i_item.write_data, i_item.reg_index == REG_PCLK1);
        unique case (i_item.func)
            FUNC_READ: begin
                unique case (i_item.reg_index)
                    REG_FSEL0, REG_FSEL1, REG_FSEL2,
                    REG_FSEL3, REG_FSEL4, REG_FSEL5: rd = fsel_word;
                    REG_LEV0, REG_LEV1: rd = bank_read(r_last, i_item.reg_index[0]);
                    REG_EVS0, REG_EVS1: rd = bank_read(r_event, i_item.reg_index[0]);
                    REG_REN0, REG_REN1: rd = bank_read(r_rise, i_item.reg_index[0]);
                    REG_FEN0, REG_FEN1: rd = bank_read(r_fall, i_item.reg_index[0]);
                    REG_PULL: rd = {30'd0, r_pull_ctl};
                    default: rd = '0;
                endcase
            end
            FUNC_WRITE: begin
                unique case (i_item.reg_index)
                    REG_FSEL0, REG_FSEL1, REG_FSEL2,
                    REG_FSEL3, REG_FSEL4, REG_FSEL5: begin
                        for (int w = 0; w < FSEL_WORDS; w++) begin
                            for (int k = 0; k < PINS_PER_FSEL; k++) begin
                                if (w * PINS_PER_FSEL + k < NUM_PINS &&
                                    i_item.reg_index == 5'(w)) begin
                                    n_fsel[w * PINS_PER_FSEL + k] =
                                        i_item.write_data[FSEL_BITS*k +: FSEL_BITS];
                                end
                            end
                        end
                    end
                    REG_SET0, REG_SET1: begin
                        n_latch = r_latch | bank_bits(i_item.write_data,
                                                      i_item.reg_index[0]);
                    end
                    REG_CLR0, REG_CLR1: begin
                        n_latch = r_latch & ~bank_bits(i_item.write_data,
                                                       i_item.reg_index[0]);
                    end
                    REG_EVS0, REG_EVS1: begin
                        n_event = r_event & ~bank_bits(i_item.write_data,
                                                       i_item.reg_index[0]);
                    end
                    REG_REN0, REG_REN1: begin
                        n_rise = bank_replace(r_rise, i_item.write_data, i_item.reg_index[0]);
                    end
                    REG_FEN0, REG_FEN1: begin
                        n_fall = bank_replace(r_fall, i_item.write_data, i_item.reg_index[0]);
                    end
                    REG_PULL: n_pull_ctl = i_item.write_data[1:0];
                    REG_PCLK0, REG_PCLK1: begin
                        for (int p = 0; p < NUM_PINS; p++) begin
                            if (sel[p]) begin
                                n_pull[p] = r_pull_ctl;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                n_event = r_event | (levels & ~r_last & r_rise) | (~levels & r_last & r_fall);
                n_last  = levels;
            end
            default: ;
        endcase
    end

    // pin-facing outputs follow the state as it stands after the item
    always_comb begin
        for (int p = 0; p < NUM_PINS; p++) begin
            en[p]   = n_fsel[p] == FSEL_OUTPUT;
            up[p]   = n_pull[p] == PULL_UP;
            down[p] = n_pull[p] == PULL_DOWN;
        end
    end

    assign w_latch = WIDE_BITS'(n_latch);
    assign w_en    = WIDE_BITS'(en);
    assign w_up    = WIDE_BITS'(up);
    assign w_down  = WIDE_BITS'(down);

    assign o_result.read_data         = rd;
    assign o_result.drive_low         = w_latch[BANK_BITS-1:0];
    assign o_result.drive_high        = w_latch[BANK_BITS +: HIGH_BITS];
    assign o_result.drive_enable_low  = w_en[BANK_BITS-1:0];
    assign o_result.drive_enable_high = w_en[BANK_BITS +: HIGH_BITS];
    assign o_result.pull_up_low       = w_up[BANK_BITS-1:0];
    assign o_result.pull_up_high      = w_up[BANK_BITS +: HIGH_BITS];
    assign o_result.pull_down_low     = w_down[BANK_BITS-1:0];
    assign o_result.pull_down_high    = w_down[BANK_BITS +: HIGH_BITS];
    assign o_result.event_pending     = |n_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PINS; p++) begin
                r_fsel[p] <= '0;
                r_pull[p] <= PULL_OFF;
            end
            r_latch    <= '0;
            r_event    <= '0;
            r_rise     <= '0;
            r_fall     <= '0;
            r_last     <= '0;
            r_pull_ctl <= PULL_OFF;
        end else if (i_flow.step) begin
            r_fsel     <= n_fsel;
            r_pull     <= n_pull;
            r_latch    <= n_latch;
            r_event    <= n_event;
            r_rise     <= n_rise;
            r_fall     <= n_fall;
            r_last     <= n_last;
            r_pull_ctl <= n_pull_ctl;
        end
    end

endmodule

FILE: design/gcr_out_stage.sv
module gcr_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcr_pkg::t_flow     i_flow,
    input  gcr_pkg::t_out_item i_result,
    output logic               o_advance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output gcr_pkg::t_out_item o_out
);
    import gcr_pkg::*;

    logic      r_valid;
    logic      n_valid;
    t_out_item r_out;

    // the result register is empty or is taken in this cycle
    assign o_advance = !r_valid || !i_out_stall;
    assign n_valid   = i_flow.advance ? i_flow.step : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.step) begin
            r_out <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

FILE: test/gpio_controller_registers_checker.sv
`timescale 1ns / 100ps

module gpio_controller_registers_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  gcr_pkg::t_in_item  i_in,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  gcr_pkg::t_out_item i_out,
    input  logic               i_finish,
    output int                 o_pending,
    output int                 o_fail_count
);
    import gcr_pkg::*;

    logic [FSEL_BITS-1:0] pin_function [NUM_PINS];
    logic [1:0]           pin_pull [NUM_PINS];
    t_pins                out_latch;
    t_pins                event_bits;
    t_pins                rise_watch;
    t_pins                fall_watch;
    t_pins                sampled_levels;
    logic [1:0]           pull_code;

    t_out_item expected_outputs [$];
    int        fail_count = 0;
    bit        finish_seen = 1'b0;

    assign o_fail_count = fail_count;

    // bank word onto pin positions, anything past the last pin dropped
    function automatic t_pins word_to_pins(input logic [31:0] data, input logic upper);
        t_pins w;
        if (upper) begin
            w = {data[HIGH_BITS-1:0], 32'h0};
        end else begin
            w = t_pins'(data);
        end
        return w;
    endfunction

    function automatic logic [31:0] pins_to_word(input t_pins v, input logic upper);
        logic [31:0] w;
        if (upper) begin
            w = 32'(v[NUM_PINS-1:BANK_BITS]);
        end else begin
            w = v[BANK_BITS-1:0];
        end
        return w;
    endfunction

    function automatic t_pins swap_word(input t_pins v, input logic [31:0] data,
                                        input logic upper);
        t_pins w;
        if (upper) begin
            w = {data[HIGH_BITS-1:0], v[BANK_BITS-1:0]};
        end else begin
            w = {v[NUM_PINS-1:BANK_BITS], data};
        end
        return w;
    endfunction

    task automatic clear_pin_state();
        int p;
        for (p = 0; p < NUM_PINS; p++) begin
            pin_function[p] = '0;
            pin_pull[p]     = PULL_OFF;
        end
        out_latch      = '0;
        event_bits     = '0;
        rise_watch     = '0;
        fall_watch     = '0;
        sampled_levels = '0;
        pull_code      = PULL_OFF;
    endtask

    task automatic gpio_step(input t_in_item it, output t_out_item res);
        logic [31:0] rd;
        logic [31:0] d;
        t_pins       sel;
        t_pins       lv;
        t_pins       en;
        t_pins       up;
        t_pins       down;
        int          p;
        int          k;
        rd = '0;
        d  = it.write_data;
        case (it.func)
            FUNC_READ: begin
                case (it.reg_index)
                    REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3, REG_FSEL4, REG_FSEL5: begin
                        for (k = 0; k < PINS_PER_FSEL; k++) begin
                            p = int'(it.reg_index) * PINS_PER_FSEL + k;
                            if (p < NUM_PINS) rd[FSEL_BITS*k +: FSEL_BITS] = pin_function[p];
                        end
                    end
                    REG_LEV0, REG_LEV1:
                        rd = pins_to_word(sampled_levels, it.reg_index == REG_LEV1);
                    REG_EVS0, REG_EVS1:
                        rd = pins_to_word(event_bits, it.reg_index == REG_EVS1);
                    REG_REN0, REG_REN1:
                        rd = pins_to_word(rise_watch, it.reg_index == REG_REN1);
                    REG_FEN0, REG_FEN1:
                        rd = pins_to_word(fall_watch, it.reg_index == REG_FEN1);
                    REG_PULL:
                        rd = 32'(pull_code);
                    default: rd = '0;
                endcase
            end
            FUNC_WRITE: begin
                case (it.reg_index)
                    REG_FSEL0, REG_FSEL1, REG_FSEL2, REG_FSEL3, REG_FSEL4, REG_FSEL5: begin
                        for (k = 0; k < PINS_PER_FSEL; k++) begin
                            p = int'(it.reg_index) * PINS_PER_FSEL + k;
                            if (p < NUM_PINS) pin_function[p] = d[FSEL_BITS*k +: FSEL_BITS];
                        end
                    end
                    REG_SET0, REG_SET1:
                        out_latch |= word_to_pins(d, it.reg_index == REG_SET1);
                    REG_CLR0, REG_CLR1:
                        out_latch &= ~word_to_pins(d, it.reg_index == REG_CLR1);
                    REG_EVS0, REG_EVS1:
                        event_bits &= ~word_to_pins(d, it.reg_index == REG_EVS1);
                    REG_REN0, REG_REN1:
                        rise_watch = swap_word(rise_watch, d, it.reg_index == REG_REN1);
                    REG_FEN0, REG_FEN1:
                        fall_watch = swap_word(fall_watch, d, it.reg_index == REG_FEN1);
                    REG_PULL:
                        pull_code = d[1:0];
                    REG_PCLK0, REG_PCLK1: begin
                        sel = word_to_pins(d, it.reg_index == REG_PCLK1);
                        for (p = 0; p < NUM_PINS; p++) begin
                            if (sel[p]) pin_pull[p] = pull_code;
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_TICK: begin
                lv = {it.pins_in_high, it.pins_in_low};
                event_bits |= (lv & ~sampled_levels & rise_watch) |
                              (~lv & sampled_levels & fall_watch);
                sampled_levels = lv;
            end
            default: ;
        endcase

        for (p = 0; p < NUM_PINS; p++) begin
            en[p]   = pin_function[p] == FSEL_OUTPUT;
            up[p]   = pin_pull[p] == PULL_UP;
            down[p] = pin_pull[p] == PULL_DOWN;
        end

        res.read_data         = rd;
        res.drive_low         = out_latch[BANK_BITS-1:0];
        res.drive_high        = out_latch[NUM_PINS-1:BANK_BITS];
        res.drive_enable_low  = en[BANK_BITS-1:0];
        res.drive_enable_high = en[NUM_PINS-1:BANK_BITS];
        res.pull_up_low       = up[BANK_BITS-1:0];
        res.pull_up_high      = up[NUM_PINS-1:BANK_BITS];
        res.pull_down_low     = down[BANK_BITS-1:0];
        res.pull_down_high    = down[NUM_PINS-1:BANK_BITS];
        res.event_pending     = |event_bits;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_outputs(input t_out_item want, input t_out_item got);
        check_field("read_data", want.read_data, got.read_data);
        check_field("drive_low", want.drive_low, got.drive_low);
        check_field("drive_high", 32'(want.drive_high), 32'(got.drive_high));
        check_field("drive_enable_low", want.drive_enable_low, got.drive_enable_low);
        check_field("drive_enable_high", 32'(want.drive_enable_high),
                    32'(got.drive_enable_high));
        check_field("pull_up_low", want.pull_up_low, got.pull_up_low);
        check_field("pull_up_high", 32'(want.pull_up_high), 32'(got.pull_up_high));
        check_field("pull_down_low", want.pull_down_low, got.pull_down_low);
        check_field("pull_down_high", 32'(want.pull_down_high), 32'(got.pull_down_high));
        check_field("event_pending", 32'(want.event_pending), 32'(got.event_pending));
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_pin_state();
            expected_outputs.delete();
        end else begin
            // a result never leaves at the clock edge that accepts its item, so compare first
            if (i_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    $error("result item arrived with nothing expected");
                    fail_count++;
                end else begin
                    want = expected_outputs.pop_front();
                    compare_outputs(want, i_out);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                gpio_step(i_in, want);
                expected_outputs.push_back(want);
            end
            if (i_finish && !finish_seen) begin
                finish_seen = 1'b1;
                if (expected_outputs.size() != 0) begin
                    $error("%0d expected result items never arrived",
                           expected_outputs.size());
                    fail_count++;
                end
            end
        end
        o_pending = expected_outputs.size();
    end

endmodule

FILE: test/gpio_controller_registers_test.sv
`timescale 1ns / 100ps

module gpio_controller_registers_test;
    import gcr_pkg::*;

    localparam logic [1:0]  FUNC_UNUSED        = 2'd3;
    localparam logic [4:0]  REG_FIRST_UNMAPPED = 5'd21;
    localparam logic [4:0]  REG_LAST_INDEX     = 5'd31;
    // every field of a select word set to output, spare top bits too
    localparam logic [31:0] ALL_OUTPUT         = 32'hC924_9249;
    localparam int          RANDOM_PER_PHASE   = 630;
    localparam int          DRAIN_LIMIT        = 2000;
    localparam int          SETTLE_CYCLES      = 10;
    localparam int          RUN_LIMIT_NS       = 2_000_000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      finish    = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    int        pending;
    int        fail_count;
    int        send_idle_pct  = 38;
    int        recv_stall_pct = 55;

    gpio_controller_registers i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    gpio_controller_registers_checker i_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_item),
        .i_finish     (finish),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic bus(input logic [1:0] func, input logic [4:0] idx,
                       input logic [31:0] data);
        t_in_item it;
        it.func         = func;
        it.reg_index    = idx;
        it.write_data   = data;
        it.pins_in_low  = $urandom;
        it.pins_in_high = HIGH_BITS'($urandom);
        send(it);
    endtask

    task automatic tick(input logic [31:0] lo, input logic [HIGH_BITS-1:0] hi);
        t_in_item it;
        it.func         = FUNC_TICK;
        it.reg_index    = 5'($urandom);
        it.write_data   = $urandom;
        it.pins_in_low  = lo;
        it.pins_in_high = hi;
        send(it);
    endtask

    task automatic send_random();
        t_in_item it;
        int       pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.func = FUNC_READ;
        end else if (pick < 70) begin
            it.func = FUNC_WRITE;
        end else if (pick < 95) begin
            it.func = FUNC_TICK;
        end else begin
            it.func = FUNC_UNUSED;
        end
        if ($urandom_range(9) == 0) begin
            it.reg_index = 5'($urandom_range(REG_LAST_INDEX, REG_FIRST_UNMAPPED));
        end else begin
            it.reg_index = 5'($urandom_range(REG_PCLK1));
        end
        // sparse words keep the latches and enables from saturating
        if ($urandom_range(2) == 0) begin
            it.write_data = $urandom & $urandom;
        end else begin
            it.write_data = $urandom;
        end
        it.pins_in_low  = $urandom;
        it.pins_in_high = HIGH_BITS'($urandom);
        send(it);
    endtask

    initial begin
        int waited;
        int phase;
        waited = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        bus(FUNC_READ, REG_LAST_INDEX, '1);
        bus(FUNC_WRITE, REG_FIRST_UNMAPPED, '1);
        bus(FUNC_UNUSED, REG_LAST_INDEX, '1);
        bus(FUNC_WRITE, REG_REN0, '1);
        bus(FUNC_WRITE, REG_REN1, '1);
        bus(FUNC_WRITE, REG_FEN0, '1);
        // first sample after reset: every high pin is a rising edge
        tick('1, '1);
        bus(FUNC_READ, REG_EVS1, '0);
        bus(FUNC_READ, REG_LEV1, '0);
        tick('0, '0);
        bus(FUNC_WRITE, REG_EVS0, '1);
        bus(FUNC_WRITE, REG_LEV0, '1);
        bus(FUNC_READ, REG_LEV0, '0);
        bus(FUNC_WRITE, REG_FSEL5, '1);
        bus(FUNC_READ, REG_FSEL5, '0);
        bus(FUNC_WRITE, REG_FSEL0, ALL_OUTPUT);
        bus(FUNC_WRITE, REG_SET1, '1);
        bus(FUNC_READ, REG_SET1, '0);
        bus(FUNC_WRITE, REG_SET0, '1);
        bus(FUNC_WRITE, REG_CLR0, 32'h5555_5555);
        bus(FUNC_WRITE, REG_PULL, '1);
        bus(FUNC_WRITE, REG_PCLK1, '1);
        bus(FUNC_WRITE, REG_PULL, 32'(PULL_UP));
        bus(FUNC_WRITE, REG_PCLK0, '1);
        bus(FUNC_WRITE, REG_PULL, 32'(PULL_DOWN));
        bus(FUNC_WRITE, REG_PCLK0, 32'h0000_FFFF);
        bus(FUNC_READ, REG_PULL, '0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 38;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 38;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (RANDOM_PER_PHASE) send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        finish <= 1'b1;
        @(negedge clk);

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
